// ===== hw/rtl/tmst_pkg.sv =====
// ----------------------------------------------------------------------------
// Tempo map package
// Shared widths, codes and reset values for the seconds-to-ticks converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tmst_pkg;

  localparam int MAX_POINTS_DEFAULT = 16;

  localparam int TIME_W  = 32;
  localparam int TEMPO_W = 18;
  localparam int RES_W   = 16;
  localparam int COUNT_W = 5;
  localparam int SLOT_W  = 4;
  localparam int TICK_W  = 37;

  localparam int LEN_W  = TIME_W + 1;
  localparam int PROD_W = LEN_W + TEMPO_W;
  localparam int ACC_W  = PROD_W + 6;
  localparam int MAG_W  = ACC_W - 1;
  localparam int SP_W   = MAG_W + RES_W;

  localparam int SCALE_SHIFT = 26;
  localparam int DV_W        = SP_W + 1 - SCALE_SHIFT;
  localparam int DIVISOR     = 15;
  localparam int REM_W       = 4;
  localparam logic [SP_W:0] ROUND_BIAS = (SP_W + 1)'(DIVISOR) << (SCALE_SHIFT - 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;
  localparam logic [CFG_IDX_W-1:0] CFG_RESOLUTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPO      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT      = 2'd2;

  localparam logic [RES_W-1:0]   RESOLUTION_RESET = 16'd480;
  localparam logic [TEMPO_W-1:0] TEMPO_RESET      = 18'd30720;
  localparam logic [COUNT_W-1:0] COUNT_RESET      = 5'd0;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

`default_nettype wire

// ===== hw/rtl/tmst_scale.sv =====
// ----------------------------------------------------------------------------
// Tempo map result scaler
// Multiplies the positive time-tempo sum by the resolution one bit a cycle,
// adds the rounding bias, drops the power-of-two part of the scale and divides
// by fifteen one bit a cycle, then saturates to the tick width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmst_scale (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [tmst_pkg::MAG_W-1:0]       mag,
  input  logic [tmst_pkg::RES_W-1:0]       resolution,
  output logic                             done,
  output logic [tmst_pkg::TICK_W-1:0]      ticks
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_RND  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]                       state;
  logic [5:0]                       cnt;
  logic [tmst_pkg::MAG_W-1:0]       mag_r;
  logic [tmst_pkg::RES_W-1:0]       res_sh;
  logic [tmst_pkg::SP_W-1:0]        prod;
  logic [tmst_pkg::SP_W-1:0]        prod_next;
  logic [tmst_pkg::SP_W:0]          biased;
  logic [tmst_pkg::DV_W-1:0]        dv;
  logic [tmst_pkg::REM_W-1:0]       rem;
  logic [tmst_pkg::REM_W:0]         rem_wide;
  logic                             rem_ge;

  assign prod_next = {prod[tmst_pkg::SP_W-2:0], 1'b0}
                   + (res_sh[tmst_pkg::RES_W-1] ? tmst_pkg::SP_W'(mag_r)
                                                : {tmst_pkg::SP_W{1'b0}});
  assign biased    = {1'b0, prod} + tmst_pkg::ROUND_BIAS;
  assign rem_wide  = {rem, dv[tmst_pkg::DV_W-1]};
  assign rem_ge    = rem_wide >= (tmst_pkg::REM_W + 1)'(tmst_pkg::DIVISOR);

  assign done  = (state == S_FIN);
  assign ticks = (|dv[tmst_pkg::DV_W-1:tmst_pkg::TICK_W]) ? {tmst_pkg::TICK_W{1'b1}}
                                                          : dv[tmst_pkg::TICK_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            mag_r  <= mag;
            res_sh <= resolution;
            prod   <= '0;
            cnt    <= '0;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          prod   <= prod_next;
          res_sh <= {res_sh[tmst_pkg::RES_W-2:0], 1'b0};
          cnt    <= cnt + 6'd1;
          if (cnt == 6'(tmst_pkg::RES_W - 1)) begin
            state <= S_RND;
          end
        end
        S_RND: begin
          dv    <= biased[tmst_pkg::SP_W:tmst_pkg::SCALE_SHIFT];
          rem   <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          dv  <= {dv[tmst_pkg::DV_W-2:0], rem_ge};
          rem <= rem_ge ? tmst_pkg::REM_W'(rem_wide - (tmst_pkg::REM_W + 1)'(tmst_pkg::DIVISOR))
                        : rem_wide[tmst_pkg::REM_W-1:0];
          cnt <= cnt + 6'd1;
          if (cnt == 6'(tmst_pkg::DV_W - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tempo_map_seconds_to_ticks.sv =====
// ----------------------------------------------------------------------------
// Tempo map seconds-to-ticks converter
// Holds a table of tempo points and turns a time into a rounded tick position.
// ----------------------------------------------------------------------------
// A point write is taken while the block is idle and leaves it ready again at once.
// A query walks the table: each segment that ends before the query time costs a
// bit-serial tempo multiply, as does the last part up to the query time, and each
// point at time zero costs a step of the walk. The final scaling costs a serial
// resolution multiply and a serial divide by fifteen.
// A zero query time or zero resolution skips the walk and gives a zero result. The
// next item is taken once the result has been placed in the output register,
// and it may be taken while that result still waits for its transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tempo_map_seconds_to_ticks #(
  parameter int MAX_POINTS = tmst_pkg::MAX_POINTS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [tmst_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tmst_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                opcode,
  input  logic [tmst_pkg::SLOT_W-1:0]         point_index,
  input  logic [tmst_pkg::TIME_W-1:0]         point_time,
  input  logic [tmst_pkg::TEMPO_W-1:0]        point_tempo,
  input  logic [tmst_pkg::TIME_W-1:0]         query_time,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tmst_pkg::TICK_W-1:0]         tick_count
);

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WALK  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_ACC   = 3'd3;
  localparam logic [2:0] ST_SCALE = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [tmst_pkg::TIME_W-1:0]          point_times  [MAX_POINTS];
  logic [tmst_pkg::TEMPO_W-1:0]         point_tempos [MAX_POINTS];

  logic [tmst_pkg::RES_W-1:0]           tick_resolution;
  logic [tmst_pkg::TEMPO_W-1:0]         default_tempo;
  logic [tmst_pkg::COUNT_W-1:0]         point_count;

  logic [2:0]                           state;
  logic [tmst_pkg::TIME_W-1:0]          q_time;
  logic [CNT_W-1:0]                     idx;
  logic [CNT_W-1:0]                     n_pts;
  logic                                 last_seg;
  logic [tmst_pkg::TIME_W-1:0]          prev_time;
  logic [tmst_pkg::TEMPO_W-1:0]         prev_tempo;
  logic signed [tmst_pkg::LEN_W-1:0]    seg_len;
  logic [tmst_pkg::TEMPO_W-1:0]         mul_tempo;
  logic [4:0]                           bit_cnt;
  logic signed [tmst_pkg::PROD_W-1:0]   prod;
  logic signed [tmst_pkg::PROD_W-1:0]   prod_next;
  logic signed [tmst_pkg::ACC_W-1:0]    acc;
  logic signed [tmst_pkg::ACC_W-1:0]    acc_next;
  logic [tmst_pkg::TICK_W-1:0]          ticks;

  logic                                 accept;
  logic [IDX_W-1:0]                     wr_slot;
  logic [IDX_W-1:0]                     rd_slot;
  logic [tmst_pkg::TIME_W-1:0]          cur_time;
  logic [tmst_pkg::TEMPO_W-1:0]         cur_tempo;
  logic                                 acc_nonpos;
  logic                                 scale_start;
  logic                                 scale_done;
  logic [tmst_pkg::TICK_W-1:0]          scale_ticks;

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign wr_slot   = IDX_W'(point_index);
  assign rd_slot   = idx[IDX_W-1:0];
  assign cur_time  = point_times[rd_slot];
  assign cur_tempo = point_tempos[rd_slot];
  assign n_pts     = (32'(point_count) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
                                                     : CNT_W'(point_count);

  assign prod_next = {prod[tmst_pkg::PROD_W-2:0], 1'b0}
                   + (mul_tempo[tmst_pkg::TEMPO_W-1]
                      ? {{tmst_pkg::TEMPO_W{seg_len[tmst_pkg::LEN_W-1]}}, seg_len}
                      : {tmst_pkg::PROD_W{1'b0}});
  assign acc_next  = acc + {{(tmst_pkg::ACC_W - tmst_pkg::PROD_W){prod[tmst_pkg::PROD_W-1]}},
                            prod};
  assign acc_nonpos  = acc_next[tmst_pkg::ACC_W-1] || (acc_next == '0);
  assign scale_start = (state == ST_ACC) && last_seg && !acc_nonpos;

  tmst_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .start      (scale_start),
    .mag        (acc_next[tmst_pkg::MAG_W-1:0]),
    .resolution (tick_resolution),
    .done       (scale_done),
    .ticks      (scale_ticks)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_resolution <= tmst_pkg::RESOLUTION_RESET;
      default_tempo   <= tmst_pkg::TEMPO_RESET;
      point_count     <= tmst_pkg::COUNT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tmst_pkg::CFG_RESOLUTION: tick_resolution <= cfg_data[tmst_pkg::RES_W-1:0];
        tmst_pkg::CFG_TEMPO:      default_tempo   <= cfg_data;
        tmst_pkg::CFG_COUNT:      point_count     <= cfg_data[tmst_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (opcode == tmst_pkg::OP_WRITE) && (32'(point_index) < MAX_POINTS)) begin
      point_times[wr_slot]  <= point_time;
      point_tempos[wr_slot] <= point_tempo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && (opcode == tmst_pkg::OP_QUERY)) begin
            q_time     <= query_time;
            idx        <= '0;
            acc        <= '0;
            prev_time  <= '0;
            prev_tempo <= (n_pts != '0) ? point_tempos[0] : default_tempo;
            if ((query_time == '0) || (tick_resolution == '0)) begin
              ticks <= '0;
              state <= ST_OUT;
            end else begin
              state <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          prod    <= '0;
          bit_cnt <= '0;
          if ((idx == n_pts) || ((cur_time != '0) && (q_time <= cur_time))) begin
            seg_len   <= $signed({1'b0, q_time}) - $signed({1'b0, prev_time});
            mul_tempo <= prev_tempo;
            last_seg  <= 1'b1;
            state     <= ST_MUL;
          end else if (cur_time == '0) begin
            prev_tempo <= cur_tempo;
            idx        <= idx + 1'b1;
          end else begin
            seg_len    <= $signed({1'b0, cur_time}) - $signed({1'b0, prev_time});
            mul_tempo  <= prev_tempo;
            last_seg   <= 1'b0;
            prev_time  <= cur_time;
            prev_tempo <= cur_tempo;
            idx        <= idx + 1'b1;
            state      <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod      <= prod_next;
          mul_tempo <= {mul_tempo[tmst_pkg::TEMPO_W-2:0], 1'b0};
          bit_cnt   <= bit_cnt + 5'd1;
          if (bit_cnt == 5'(tmst_pkg::TEMPO_W - 1)) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          acc <= acc_next;
          if (!last_seg) begin
            state <= ST_WALK;
          end else if (acc_nonpos) begin
            ticks <= '0;
            state <= ST_OUT;
          end else begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (scale_done) begin
            ticks <= scale_ticks;
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            tick_count <= ticks;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tmst_checker.sv =====
// ----------------------------------------------------------------------------
// Tempo map port checker
// Watches the ports of the converter over time and is bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmst_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           opcode,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [tmst_pkg::TICK_W-1:0]    tick_count
);

  // A result held back by the receiver stays put until its transfer.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tick_count))
    else $error("stalled result changed or was dropped");

  // A point write is finished in its own cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (opcode == tmst_pkg::OP_WRITE) |=> !in_stall)
    else $error("point write left the block busy");

  // A query keeps the block busy until its result is produced.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (opcode == tmst_pkg::OP_QUERY) |=> in_stall)
    else $error("query did not occupy the block");

  // A new result only appears at the end of a query.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a query in progress");

endmodule

bind tempo_map_seconds_to_ticks tmst_checker u_checker (.*);

`default_nettype wire
